>>> sv/assert_macros.svh
// Assertion macros used by the port-level checker of the drive mixer.
// Each macro samples on clk and is switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ADM_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("drive mixer port property violated");

// Next-cycle implication.
`define ADM_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("drive mixer port property violated");

`endif

>>> sv/adm_pkg.sv
// Shared types, constants and arithmetic helpers of the arcade drive mixer.
// No dependencies; every module of the block except adm_delay imports it.
package adm_pkg;

    localparam int FRAC_BITS = 14;
    // Register stages: one front stage, the cubic blend, three mixing stages.
    localparam int CUB_LAT   = 6;
    localparam int MIX_LAT   = 3;
    localparam int NSTG      = CUB_LAT + MIX_LAT + 1;

    localparam logic [14:0] THRUST_DB_RST = 15'd1638;
    localparam logic [14:0] ROTATE_DB_RST = 15'd983;

    // Configuration register indexes.
    localparam logic REG_THRUST_DB = 1'b0;
    localparam logic REG_ROTATE_DB = 1'b1;

    localparam logic signed [15:0] ONE_16 = 16'sd1 <<< FRAC_BITS;
    localparam logic signed [16:0] ONE_17 = 17'sd1 <<< FRAC_BITS;
    localparam logic signed [23:0] ONE_24 = 24'sd1 <<< FRAC_BITS;

    // Values that ride alongside the cubic blend to the mixing stages.
    typedef struct packed {
        logic               qt;
        logic signed [15:0] ql;
        logic signed [15:0] qr;
        logic        [15:0] mthr;
    } side_t;

    localparam int SIDE_W = $bits(side_t);

    // Divide by 2^n, rounding to nearest with ties away from zero.
    // Negative values take a bias one smaller, which mirrors the positive case.
    function automatic logic signed [39:0] rnd_shr(input logic signed [39:0] x,
                                                   input int n);
        logic signed [39:0] bias;
        logic signed [39:0] s;
        bias = 40'sd1 <<< (n - 1);
        if (x[39])
        begin
            bias = bias - 40'sd1;
        end
        s = x + bias;
        return s >>> n;
    endfunction

    function automatic logic [15:0] mag17(input logic signed [16:0] x);
        logic signed [16:0] neg;
        neg = -x;
        return x[16] ? neg[15:0] : x[15:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [23:0] x);
        logic signed [23:0] y;
        if (x > ONE_24)
        begin
            y = ONE_24;
        end
        else if (x < -ONE_24)
        begin
            y = -ONE_24;
        end
        else
        begin
            y = x;
        end
        return y[15:0];
    endfunction

endpackage

>>> sv/adm_delay.sv
// Enable-controlled delay line that carries side values along the pipeline.
// Depends on nothing but its parameters.
module adm_delay #(
    parameter int W = 8,
    parameter int N = 2
) (
    input  logic         clk,
    input  logic [N-1:0] en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] stage_reg [N];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            stage_reg[0] <= d;
        end
        for (int k = 1; k < N; k++)
        begin
            if (en[k])
            begin
                stage_reg[k] <= stage_reg[k-1];
            end
        end
    end

    assign q = stage_reg[N-1];

endmodule

>>> sv/adm_ctrl.sv
// Valid bits and per-stage load enables of the mixer pipeline.
// Uses adm_pkg for the stage count.
module adm_ctrl
    import adm_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            out_ready,
    output logic            in_ready,
    output logic            out_valid,
    output logic [NSTG-1:0] en
);

    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] v_next;

    // A stage may load when it is empty or when its content moves on,
    // so bubbles are squeezed out even while the output is stalled.
    always_comb
    begin
        en[NSTG-1] = !v_reg[NSTG-1] || out_ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
        v_next[0] = en[0] ? in_valid : v_reg[0];
        for (int k = 1; k < NSTG; k++)
        begin
            v_next[k] = en[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NSTG-1];

endmodule

>>> sv/adm_front.sv
// Input stage: deadband registers, thrust sign, deadbands and quick-turn values.
// Uses adm_pkg for constants, side_t and the helper functions.
module adm_front
    import adm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [14:0]        cfg_data,
    input  logic               en,
    input  logic signed [15:0] left_y_axis,
    input  logic signed [15:0] rotate_axis,
    input  logic signed [15:0] left_z_axis,
    input  logic signed [15:0] right_z_axis,
    input  logic               reverse_drive,
    input  logic               quick_turn,
    output logic signed [16:0] thr,
    output logic signed [16:0] rot,
    output logic signed [15:0] lz,
    output logic signed [15:0] rz,
    output side_t              side
);

    logic [14:0] thr_db_reg;
    logic [14:0] rot_db_reg;

    logic signed [16:0] thr_reg;
    logic signed [16:0] rot_reg;
    logic signed [15:0] lz_reg;
    logic signed [15:0] rz_reg;
    side_t              side_reg;

    logic signed [16:0] ly_x;
    logic signed [16:0] rx_x;
    logic signed [16:0] thr_raw;
    logic signed [16:0] thr_next;
    logic signed [16:0] rot_next;
    logic        [15:0] thr_mag;
    logic        [15:0] rot_mag;
    side_t              side_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_db_reg <= THRUST_DB_RST;
            rot_db_reg <= ROTATE_DB_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_THRUST_DB: thr_db_reg <= cfg_data;
                REG_ROTATE_DB: rot_db_reg <= cfg_data;
            endcase
        end
    end

    always_comb
    begin
        ly_x    = {left_y_axis[15], left_y_axis};
        rx_x    = {rotate_axis[15], rotate_axis};
        // The stick's Y axis reads negative when pushed forward.
        thr_raw = reverse_drive ? ly_x : -ly_x;
        thr_mag = mag17(thr_raw);
        rot_mag = mag17(rx_x);
        // A magnitude equal to the bound passes.
        thr_next = (thr_mag < {1'b0, thr_db_reg}) ? 17'sd0 : thr_raw;
        rot_next = (rot_mag < {1'b0, rot_db_reg}) ? 17'sd0 : rx_x;
        side_next.qt   = quick_turn;
        side_next.ql   = sat16(24'(rx_x));
        side_next.qr   = sat16(-24'(rx_x));
        side_next.mthr = mag17(thr_next);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            thr_reg  <= thr_next;
            rot_reg  <= rot_next;
            lz_reg   <= left_z_axis;
            rz_reg   <= right_z_axis;
            side_reg <= side_next;
        end
    end

    assign thr  = thr_reg;
    assign rot  = rot_reg;
    assign lz   = lz_reg;
    assign rz   = rz_reg;
    assign side = side_reg;

endmodule

>>> sv/adm_cubic.sv
// Six-stage pipelined cubic blend s*v^3 + (1-s)*v with s = (z+1)/2.
// Uses adm_pkg for ONE and the rounding helper.
module adm_cubic
    import adm_pkg::*;
(
    input  logic               clk,
    input  logic [CUB_LAT-1:0] en,
    input  logic signed [16:0] v,
    input  logic signed [15:0] z,
    output logic signed [19:0] res
);

    logic signed [33:0] psq_reg;
    logic signed [16:0] v1_reg;
    logic signed [16:0] wc1_reg;
    logic signed [16:0] wv1_reg;

    logic signed [17:0] sq2_reg;
    logic signed [16:0] v2_reg;
    logic signed [16:0] wc2_reg;
    logic signed [16:0] wv2_reg;

    logic signed [34:0] pcb3_reg;
    logic signed [33:0] pl3_reg;
    logic signed [16:0] wc3_reg;

    logic signed [18:0] cube4_reg;
    logic signed [33:0] pl4_reg;
    logic signed [16:0] wc4_reg;

    logic signed [35:0] pc5_reg;
    logic signed [33:0] pl5_reg;

    logic signed [19:0] res_reg;

    logic signed [16:0] z_x;
    logic signed [39:0] sq_rnd;
    logic signed [39:0] cube_rnd;
    logic signed [36:0] acc;
    logic signed [39:0] acc_rnd;

    always_comb
    begin
        z_x      = {z[15], z};
        sq_rnd   = rnd_shr(40'(psq_reg), FRAC_BITS);
        cube_rnd = rnd_shr(40'(pcb3_reg), FRAC_BITS);
        // The blend weights are 2s and 2-2s, so one extra bit comes off here.
        acc      = 37'(pc5_reg) + 37'(pl5_reg);
        acc_rnd  = rnd_shr(40'(acc), FRAC_BITS + 1);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            psq_reg <= v * v;
            v1_reg  <= v;
            wc1_reg <= z_x + ONE_17;
            wv1_reg <= ONE_17 - z_x;
        end
        if (en[1])
        begin
            sq2_reg <= sq_rnd[17:0];
            v2_reg  <= v1_reg;
            wc2_reg <= wc1_reg;
            wv2_reg <= wv1_reg;
        end
        if (en[2])
        begin
            pcb3_reg <= sq2_reg * v2_reg;
            pl3_reg  <= wv2_reg * v2_reg;
            wc3_reg  <= wc2_reg;
        end
        if (en[3])
        begin
            cube4_reg <= cube_rnd[18:0];
            pl4_reg   <= pl3_reg;
            wc4_reg   <= wc3_reg;
        end
        if (en[4])
        begin
            pc5_reg <= wc4_reg * cube4_reg;
            pl5_reg <= pl4_reg;
        end
        if (en[5])
        begin
            res_reg <= acc_rnd[19:0];
        end
    end

    assign res = res_reg;

endmodule

>>> sv/adm_mix.sv
// Three mixing stages: rotate scaled by |thrust|, rounding, saturated sum and difference or quick-turn values.
// Uses adm_pkg for side_t, the rounding helper and sat16.
module adm_mix
    import adm_pkg::*;
(
    input  logic               clk,
    input  logic [MIX_LAT-1:0] en,
    input  logic signed [19:0] thr_c,
    input  logic signed [19:0] rot_c,
    input  side_t              side,
    output logic signed [15:0] left_drive,
    output logic signed [15:0] right_drive
);

    logic signed [37:0] pr1_reg;
    logic signed [19:0] thr1_reg;
    side_t              side1_reg;

    logic signed [20:0] rot2_reg;
    logic signed [19:0] thr2_reg;
    side_t              side2_reg;

    logic signed [15:0] left_reg;
    logic signed [15:0] right_reg;

    logic signed [39:0] pr_rnd;
    logic signed [23:0] sum;
    logic signed [23:0] dif;
    logic signed [15:0] left_next;
    logic signed [15:0] right_next;

    always_comb
    begin
        pr_rnd = rnd_shr(40'(pr1_reg), FRAC_BITS);
        sum    = 24'(thr2_reg) + 24'(rot2_reg);
        dif    = 24'(thr2_reg) - 24'(rot2_reg);
        if (side2_reg.qt)
        begin
            left_next  = side2_reg.ql;
            right_next = side2_reg.qr;
        end
        else
        begin
            left_next  = sat16(sum);
            right_next = sat16(dif);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pr1_reg   <= rot_c * $signed({1'b0, side.mthr});
            thr1_reg  <= thr_c;
            side1_reg <= side;
        end
        if (en[1])
        begin
            rot2_reg  <= pr_rnd[20:0];
            thr2_reg  <= thr1_reg;
            side2_reg <= side1_reg;
        end
        if (en[2])
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
        end
    end

    assign left_drive  = left_reg;
    assign right_drive = right_reg;

endmodule

>>> sv/arcade_drive_mixer.sv
// Arcade drive mixer: joystick sample in, left and right wheel commands out.
// Depends on adm_pkg, adm_ctrl, adm_front, adm_cubic, adm_delay and adm_mix.
//
// Input beats on in_valid/in_ready carry one joystick sample; output beats on
// out_valid/out_ready carry left_drive and right_drive in Q2.14. The user must
// write the two deadband bounds via cfg_we/cfg_index/cfg_data only while the
// block is idle, which the block does not enforce; a write takes effect at the clock edge where cfg_we is high.
//
// The datapath is a ten-stage pipeline: one input stage, a six-stage cubic
// blend per axis (four multiplies each), and three mixing stages. One beat is
// accepted every cycle unless a held-low out_ready has filled every stage.
//
// When the receiver holds out_ready low, the last stage keeps its beat and
// earlier stages keep filling until every stage holds a beat; only then does
// in_ready fall. Reset empties the pipeline and restores the deadbands to 0.1
// and 0.06.
module arcade_drive_mixer
    import adm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [14:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] left_y_axis,
    input  logic signed [15:0] rotate_axis,
    input  logic signed [15:0] left_z_axis,
    input  logic signed [15:0] right_z_axis,
    input  logic               reverse_drive,
    input  logic               quick_turn,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] left_drive,
    output logic signed [15:0] right_drive
);

    logic [NSTG-1:0]    en;
    logic signed [16:0] thr;
    logic signed [16:0] rot;
    logic signed [15:0] lz;
    logic signed [15:0] rz;
    side_t              side_f;
    side_t              side_d;
    logic signed [19:0] thr_c;
    logic signed [19:0] rot_c;

    adm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_ready (out_ready),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .en        (en)
    );

    adm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .en            (en[0]),
        .left_y_axis   (left_y_axis),
        .rotate_axis   (rotate_axis),
        .left_z_axis   (left_z_axis),
        .right_z_axis  (right_z_axis),
        .reverse_drive (reverse_drive),
        .quick_turn    (quick_turn),
        .thr           (thr),
        .rot           (rot),
        .lz            (lz),
        .rz            (rz),
        .side          (side_f)
    );

    adm_cubic u_cubic_thr (
        .clk (clk),
        .en  (en[CUB_LAT:1]),
        .v   (thr),
        .z   (lz),
        .res (thr_c)
    );

    adm_cubic u_cubic_rot (
        .clk (clk),
        .en  (en[CUB_LAT:1]),
        .v   (rot),
        .z   (rz),
        .res (rot_c)
    );

    adm_delay #(
        .W (SIDE_W),
        .N (CUB_LAT)
    ) u_side_delay (
        .clk (clk),
        .en  (en[CUB_LAT:1]),
        .d   (side_f),
        .q   (side_d)
    );

    adm_mix u_mix (
        .clk         (clk),
        .en          (en[NSTG-1:CUB_LAT+1]),
        .thr_c       (thr_c),
        .rot_c       (rot_c),
        .side        (side_d),
        .left_drive  (left_drive),
        .right_drive (right_drive)
    );

endmodule

>>> sv/adm_checker.sv
// Port-level checker for the arcade drive mixer, bound to the top level.
// Depends on adm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module adm_checker
    import adm_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] left_drive,
    input logic signed [15:0] right_drive
);

    logic out_stall;
    logic out_free;
    logic left_ok;
    logic right_ok;

    assign out_stall = out_valid && !out_ready;
    assign out_free  = !out_valid || out_ready;
    assign left_ok   = (left_drive <= ONE_16) && (left_drive >= -ONE_16);
    assign right_ok  = (right_drive <= ONE_16) && (right_drive >= -ONE_16);

    // A stalled output beat keeps its values.
    `ADM_ASSERT_NXT(a_out_hold, out_stall, out_valid && $stable({left_drive, right_drive}))

    // Both commands stay within plus or minus one.
    `ADM_ASSERT_IMP(a_out_range, out_valid, left_ok && right_ok)

    // With the output free to move, the pipeline always has room for a beat.
    `ADM_ASSERT_IMP(a_ready_free, out_free, in_ready)

endmodule

bind arcade_drive_mixer adm_checker u_adm_checker (.*);
